@@ design/assert_macros.svh @@
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// concurrent check, disabled while reset is asserted (active low)
`define UDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds through reset
`define UDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define UDS_ASSERT(lbl, clk, rst_n, prop, msg)

`define UDS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ design/uds_pkg.sv @@
package uds_pkg;

    typedef struct packed {
        logic [7:0]  command;
        logic [7:0]  sub_byte;
        logic [31:0] tail_bytes;
        logic [11:0] request_length;
        logic [28:0] request_id;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [7:0] resp_byte;
        logic       extended_id;
        logic       last;
    } t_out;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIN_HEAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIN_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIN_TAIL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DTC_A     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DTC_E     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DTC_COUNT = 3'd7;

    localparam int STORED_CODES = 5;
    localparam int VIN_BYTES    = 17;

    localparam int IDX_W = 5;
    typedef logic [IDX_W-1:0] t_idx;

    localparam int PC_W = 6;
    typedef logic [PC_W-1:0] t_pc;

    // service identifiers
    localparam logic [7:0] SVC_SESSION  = 8'h10;
    localparam logic [7:0] SVC_RESET    = 8'h11;
    localparam logic [7:0] SVC_CLEAR    = 8'h14;
    localparam logic [7:0] SVC_READ_DTC = 8'h19;
    localparam logic [7:0] SVC_READ_DID = 8'h22;
    localparam logic [7:0] SVC_SECURITY = 8'h27;
    localparam logic [7:0] SVC_TESTER   = 8'h3E;

    // negative response codes
    localparam logic [7:0] NRC_NOT_SUPPORTED = 8'h11;
    localparam logic [7:0] NRC_SUBFUNCTION   = 8'h12;
    localparam logic [7:0] NRC_LENGTH        = 8'h13;
    localparam logic [7:0] NRC_RANGE         = 8'h31;
    localparam logic [7:0] NRC_BAD_KEY       = 8'h35;

    localparam logic [15:0] DID_BATTERY = 16'h1234;
    localparam logic [15:0] DID_SW_NUM  = 16'hF188;
    localparam logic [15:0] DID_VIN     = 16'hF190;

    localparam logic [28:0] STD_ID_MAX = 29'h7FF;

    localparam logic [1:0] SESSION_DEFAULT = 2'd1;

    localparam logic [7:0] SUB_DTC_COUNT = 8'h01;
    localparam logic [7:0] SUB_DTC_LIST  = 8'h02;
    localparam logic [7:0] SUB_HARD_RESET = 8'h01;

    // byte sources of the datapath
    typedef logic [3:0] t_src;
    localparam t_src SRC_CONST   = 4'd0;
    localparam t_src SRC_SUB     = 4'd1;
    localparam t_src SRC_SERVICE = 4'd2;
    localparam t_src SRC_REASON  = 4'd3;
    localparam t_src SRC_SEED    = 4'd4;
    localparam t_src SRC_BATT_HI = 4'd5;
    localparam t_src SRC_BATT_LO = 4'd6;
    localparam t_src SRC_VIN     = 4'd7;
    localparam t_src SRC_DTC_HI  = 4'd8;
    localparam t_src SRC_DTC_LO  = 4'd9;
    localparam t_src SRC_COUNT   = 4'd10;

    // last-byte selection
    typedef logic [2:0] t_last;
    localparam t_last LAST_NO       = 3'd0;
    localparam t_last LAST_YES      = 3'd1;
    localparam t_last LAST_LOOP     = 3'd2;
    localparam t_last LAST_DTC_END  = 3'd3;
    localparam t_last LAST_DTC_NONE = 3'd4;

    // jump conditions
    typedef logic [1:0] t_cond;
    localparam t_cond COND_NONE     = 2'd0;
    localparam t_cond COND_LOOP     = 2'd1;
    localparam t_cond COND_DTC_MORE = 2'd2;

    typedef struct packed {
        t_src       src;
        logic [7:0] konst;
        t_last      last_sel;
        t_cond      cond;
        logic       inc;
        t_pc        target;
    } t_uword;

    // program entry points
    localparam int ROM_DEPTH = 48;
    localparam t_pc PC_NEG      = 6'd0;
    localparam t_pc PC_SESS     = 6'd3;
    localparam t_pc PC_RESET    = 6'd9;
    localparam t_pc PC_CLEAR    = 6'd11;
    localparam t_pc PC_DTC_CNT  = 6'd12;
    localparam t_pc PC_DTC_LIST = 6'd18;
    localparam t_pc PC_DTC_LOOP = 6'd21;
    localparam t_pc PC_BATT     = 6'd25;
    localparam t_pc PC_SWVER    = 6'd30;
    localparam t_pc PC_VIN      = 6'd37;
    localparam t_pc PC_VIN_LOOP = 6'd40;
    localparam t_pc PC_SEED     = 6'd41;
    localparam t_pc PC_SEED_LOOP = 6'd43;
    localparam t_pc PC_KEY_OK   = 6'd44;
    localparam t_pc PC_TESTER   = 6'd46;

    localparam logic [7:0] VIN_END  = 8'd16;
    localparam logic [7:0] SEED_END = 8'd3;

    typedef struct packed {
        logic       respond;
        t_pc        start_pc;
        logic [7:0] reason;
        logic [7:0] sub;
        logic       session_we;
        logic [1:0] session_val;
        logic       lock;
        logic       unlock;
        logic       seed_we;
        logic       clear_codes;
    } t_dec;

    typedef struct packed {
        t_pc        pc;
        logic [7:0] service;
        logic [7:0] sub;
        logic [7:0] reason;
        logic       ext;
    } t_start;

    function automatic t_uword uw(input t_src src, input logic [7:0] konst,
                                  input t_last last_sel, input t_cond cond,
                                  input logic inc, input t_pc target);
        t_uword w;
        w.src      = src;
        w.konst    = konst;
        w.last_sel = last_sel;
        w.cond     = cond;
        w.inc      = inc;
        w.target   = target;
        return w;
    endfunction

    function automatic t_uword uds_rom(input t_pc pc);
        t_uword w;
        case (pc)
            // negative response
            6'd0:  w = uw(SRC_CONST,   8'h7F, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd1:  w = uw(SRC_SERVICE, 8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd2:  w = uw(SRC_REASON,  8'h00, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            // session control
            6'd3:  w = uw(SRC_CONST,   8'h50, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd4:  w = uw(SRC_SUB,     8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd5:  w = uw(SRC_CONST,   8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd6:  w = uw(SRC_CONST,   8'h32, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd7:  w = uw(SRC_CONST,   8'h13, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd8:  w = uw(SRC_CONST,   8'h88, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            // ecu reset
            6'd9:  w = uw(SRC_CONST,   8'h51, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd10: w = uw(SRC_CONST,   8'h01, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            // clear dtcs
            6'd11: w = uw(SRC_CONST,   8'h54, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            // dtc count
            6'd12: w = uw(SRC_CONST,   8'h59, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd13: w = uw(SRC_CONST,   8'h01, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd14: w = uw(SRC_CONST,   8'hFF, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd15: w = uw(SRC_CONST,   8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd16: w = uw(SRC_CONST,   8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd17: w = uw(SRC_COUNT,   8'h00, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            // dtc list
            6'd18: w = uw(SRC_CONST,   8'h59, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd19: w = uw(SRC_CONST,   8'h02, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd20: w = uw(SRC_CONST,   8'hFF, LAST_DTC_NONE, COND_NONE, 1'b0, PC_NEG);
            6'd21: w = uw(SRC_DTC_HI,  8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd22: w = uw(SRC_DTC_LO,  8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd23: w = uw(SRC_CONST,   8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd24: w = uw(SRC_CONST,   8'h2F, LAST_DTC_END, COND_DTC_MORE, 1'b1,
                          PC_DTC_LOOP);
            // battery voltage
            6'd25: w = uw(SRC_CONST,   8'h62, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd26: w = uw(SRC_CONST,   8'h12, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd27: w = uw(SRC_CONST,   8'h34, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd28: w = uw(SRC_BATT_HI, 8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd29: w = uw(SRC_BATT_LO, 8'h00, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            // software number
            6'd30: w = uw(SRC_CONST,   8'h62, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd31: w = uw(SRC_CONST,   8'hF1, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd32: w = uw(SRC_CONST,   8'h88, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd33: w = uw(SRC_CONST,   8'h56, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd34: w = uw(SRC_CONST,   8'h31, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd35: w = uw(SRC_CONST,   8'h2E, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd36: w = uw(SRC_CONST,   8'h30, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            // vin
            6'd37: w = uw(SRC_CONST,   8'h62, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd38: w = uw(SRC_CONST,   8'hF1, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd39: w = uw(SRC_CONST,   8'h90, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd40: w = uw(SRC_VIN,     VIN_END, LAST_LOOP, COND_LOOP, 1'b1, PC_VIN_LOOP);
            // seed
            6'd41: w = uw(SRC_CONST,   8'h67, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd42: w = uw(SRC_SUB,     8'h00, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd43: w = uw(SRC_SEED,    SEED_END, LAST_LOOP, COND_LOOP, 1'b1,
                          PC_SEED_LOOP);
            // key accepted
            6'd44: w = uw(SRC_CONST,   8'h67, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd45: w = uw(SRC_SUB,     8'h00, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            // tester present
            6'd46: w = uw(SRC_CONST,   8'h7E, LAST_NO,  COND_NONE, 1'b0, PC_NEG);
            6'd47: w = uw(SRC_CONST,   8'h00, LAST_YES, COND_NONE, 1'b0, PC_NEG);
            default: w = uw(SRC_CONST, 8'h00, LAST_YES, COND_NONE, 1'b0, PC_NEG);
        endcase
        return w;
    endfunction

endpackage

@@ design/uds_decode.sv @@
module uds_decode (
    input  uds_pkg::t_in  i_req,
    input  logic [31:0]   i_seed,
    output uds_pkg::t_dec o_dec
);
    import uds_pkg::*;

    logic [7:0]  w_sub;
    logic [15:0] w_did;

    assign w_sub = (i_req.request_length > 12'd1) ? i_req.sub_byte : 8'h00;
    assign w_did = {w_sub, i_req.tail_bytes[31:24]};

    always_comb begin
        o_dec             = '0;
        o_dec.respond     = 1'b1;
        o_dec.start_pc    = PC_NEG;
        o_dec.reason      = NRC_NOT_SUPPORTED;
        o_dec.sub         = w_sub;
        o_dec.session_val = w_sub[1:0];
        case (i_req.command)
            SVC_SESSION: begin
                if (w_sub >= 8'd1 && w_sub <= 8'd3) begin
                    o_dec.start_pc   = PC_SESS;
                    o_dec.session_we = 1'b1;
                    o_dec.lock       = (w_sub == 8'd1);
                end else begin
                    o_dec.reason = NRC_SUBFUNCTION;
                end
            end
            SVC_RESET: begin
                if (w_sub == SUB_HARD_RESET) begin
                    o_dec.start_pc    = PC_RESET;
                    o_dec.session_we  = 1'b1;
                    o_dec.session_val = SESSION_DEFAULT;
                    o_dec.lock        = 1'b1;
                end else begin
                    o_dec.reason = NRC_SUBFUNCTION;
                end
            end
            SVC_CLEAR: begin
                o_dec.start_pc    = PC_CLEAR;
                o_dec.clear_codes = 1'b1;
            end
            SVC_READ_DTC: begin
                if (w_sub == SUB_DTC_COUNT) begin
                    o_dec.start_pc = PC_DTC_CNT;
                end else if (w_sub == SUB_DTC_LIST) begin
                    o_dec.start_pc = PC_DTC_LIST;
                end else begin
                    o_dec.reason = NRC_SUBFUNCTION;
                end
            end
            SVC_READ_DID: begin
                if (i_req.request_length < 12'd3) begin
                    o_dec.reason = NRC_LENGTH;
                end else if (w_did == DID_BATTERY) begin
                    o_dec.start_pc = PC_BATT;
                end else if (w_did == DID_SW_NUM) begin
                    o_dec.start_pc = PC_SWVER;
                end else if (w_did == DID_VIN) begin
                    o_dec.start_pc = PC_VIN;
                end else begin
                    o_dec.reason = NRC_RANGE;
                end
            end
            SVC_SECURITY: begin
                if (w_sub[0]) begin
                    o_dec.start_pc = PC_SEED;
                    o_dec.seed_we  = 1'b1;
                end else if (i_req.request_length < 12'd6) begin
                    o_dec.reason = NRC_LENGTH;
                end else if (i_req.tail_bytes == i_seed + 32'd1) begin
                    o_dec.start_pc = PC_KEY_OK;
                    o_dec.unlock   = 1'b1;
                end else begin
                    o_dec.reason = NRC_BAD_KEY;
                end
            end
            SVC_TESTER: begin
                o_dec.start_pc = PC_TESTER;
                o_dec.respond  = ~w_sub[7];
            end
            default: begin
                o_dec.reason = NRC_NOT_SUPPORTED;
            end
        endcase
    end

endmodule

@@ design/uds_seq.sv @@
`include "assert_macros.svh"

module uds_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  uds_pkg::t_start      i_start_info,
    input  logic [31:0]          i_seed,
    input  logic [15:0]          i_batt,
    input  logic [63:0]          i_vin_head,
    input  logic [63:0]          i_vin_mid,
    input  logic [7:0]           i_vin_tail,
    input  logic [63:0]          i_codes_a,
    input  logic [15:0]          i_code_e,
    input  logic [7:0]           i_count,
    input  uds_pkg::t_idx        i_lim,
    output logic                 o_busy,
    output logic                 o_out_valid,
    output uds_pkg::t_out        o_out_data,
    input  logic                 i_out_stall
);
    import uds_pkg::*;

    logic       r_busy;
    t_pc        r_pc;
    t_idx       r_idx;
    logic [7:0] r_service;
    logic [7:0] r_sub;
    logic [7:0] r_reason;
    logic       r_ext;
    logic       r_out_valid;
    t_out       r_out;

    t_uword     w_uw;
    t_idx       w_idx_inc;
    logic       w_adv;
    logic       w_last;
    logic       w_jump;
    logic [7:0] w_byte;
    logic [7:0] w_seed_b;
    logic [7:0] w_vin  [VIN_BYTES];
    logic [15:0] w_code [STORED_CODES];

    assign w_uw      = uds_rom(r_pc);
    assign w_idx_inc = r_idx + t_idx'(1);
    assign w_adv     = r_busy && (!r_out_valid || !i_out_stall);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_vin[i]     = i_vin_head[63-8*i -: 8];
            w_vin[8 + i] = i_vin_mid[63-8*i -: 8];
        end
        w_vin[16] = i_vin_tail;
        for (int j = 0; j < 4; j++) begin
            w_code[j] = i_codes_a[63-16*j -: 16];
        end
        w_code[4] = i_code_e;
    end

    always_comb begin
        case (r_idx[1:0])
            2'd0:    w_seed_b = i_seed[31:24];
            2'd1:    w_seed_b = i_seed[23:16];
            2'd2:    w_seed_b = i_seed[15:8];
            default: w_seed_b = i_seed[7:0];
        endcase
    end

    always_comb begin
        case (w_uw.src)
            SRC_CONST:   w_byte = w_uw.konst;
            SRC_SUB:     w_byte = r_sub;
            SRC_SERVICE: w_byte = r_service;
            SRC_REASON:  w_byte = r_reason;
            SRC_SEED:    w_byte = w_seed_b;
            SRC_BATT_HI: w_byte = i_batt[15:8];
            SRC_BATT_LO: w_byte = i_batt[7:0];
            SRC_VIN:     w_byte = w_vin[r_idx];
            SRC_DTC_HI:  w_byte = w_code[r_idx[2:0]][15:8];
            SRC_DTC_LO:  w_byte = w_code[r_idx[2:0]][7:0];
            SRC_COUNT:   w_byte = i_count;
            default:     w_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (w_uw.last_sel)
            LAST_NO:       w_last = 1'b0;
            LAST_YES:      w_last = 1'b1;
            LAST_LOOP:     w_last = (r_idx == w_uw.konst[IDX_W-1:0]);
            LAST_DTC_END:  w_last = (w_idx_inc == i_lim);
            LAST_DTC_NONE: w_last = (i_lim == '0);
            default:       w_last = 1'b1;
        endcase
    end

    always_comb begin
        case (w_uw.cond)
            COND_NONE:     w_jump = 1'b0;
            COND_LOOP:     w_jump = (r_idx != w_uw.konst[IDX_W-1:0]);
            COND_DTC_MORE: w_jump = (w_idx_inc != i_lim);
            default:       w_jump = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= PC_NEG;
            r_idx       <= '0;
        end else begin
            if (i_start) begin
                r_busy    <= 1'b1;
                r_pc      <= i_start_info.pc;
                r_idx     <= '0;
            end else if (w_adv) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end
                r_pc <= w_jump ? w_uw.target : r_pc + t_pc'(1);
                if (w_uw.inc) begin
                    r_idx <= w_idx_inc;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction fields held for the length of one response, and the registered output byte
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_service <= i_start_info.service;
            r_sub     <= i_start_info.sub;
            r_reason  <= i_start_info.reason;
            r_ext     <= i_start_info.ext;
        end
        if (w_adv) begin
            r_out.resp_byte   <= w_byte;
            r_out.extended_id <= r_ext;
            r_out.last        <= w_last;
        end
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `UDS_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "start while busy")
    `UDS_ASSERT(a_pc_range, i_clk, i_rst_n, r_busy |-> (r_pc < t_pc'(ROM_DEPTH)), "pc out of rom")
    `UDS_ASSERT(a_last_ends, i_clk, i_rst_n, (w_adv && w_last) |=> !r_busy, "busy after last byte")
    `UDS_ASSERT(a_idx_range, i_clk, i_rst_n, r_busy |-> (r_idx <= t_idx'(VIN_BYTES - 1)), "index overrun")
    `UDS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!r_busy && !r_out_valid), "not idle after reset")

endmodule

@@ design/uds_diagnostic_server_core.sv @@
// UDS diagnostic server: one reassembled request is taken per transaction and
// answered with its response bytes, one output transaction per byte, the final
// one flagged with last. After a request is taken the block decodes it and
// updates session, security and seed state, then a microcoded sequencer steps
// one control word per response byte, holding while the output is stalled. The
// longest response is the 23-byte trouble code list, and no response is due
// when the ECU is disabled or tester present is suppressed. The next request
// may be taken while the final byte still waits at the output. Configuration
// registers are written through the plain write port; the user must write them
// only while idle, as the block itself does not enforce it.
module uds_diagnostic_server_core #(
    parameter int MAX_LISTED_CODES = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  uds_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output uds_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [uds_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [63:0]                       i_cfg_data
);
    import uds_pkg::*;

    localparam int LIST_CAP = (MAX_LISTED_CODES < STORED_CODES) ?
                              MAX_LISTED_CODES : STORED_CODES;

    logic        r_enabled;
    logic [15:0] r_batt;
    logic [63:0] r_vin_head;
    logic [63:0] r_vin_mid;
    logic [7:0]  r_vin_tail;
    logic [63:0] r_codes_a;
    logic [15:0] r_code_e;
    logic [7:0]  r_dtc_count;

    logic [1:0]  r_session;
    logic        r_unlocked;
    logic [31:0] r_seed;
    logic        r_cleared;

    logic        r_req_valid;
    t_in         r_req;

    t_dec        w_dec;
    t_start      w_start_info;
    logic        w_start;
    logic        w_busy;
    logic        w_accept;
    logic [7:0]  w_count;
    t_idx        w_lim;

    assign o_in_stall = r_req_valid | w_busy;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_start    = r_req_valid & r_enabled & w_dec.respond;

    assign w_count = r_cleared ? 8'h00 : r_dtc_count;
    assign w_lim   = (w_count < 8'(LIST_CAP)) ? w_count[IDX_W-1:0] : t_idx'(LIST_CAP);

    assign w_start_info.pc      = w_dec.start_pc;
    assign w_start_info.service = r_req.command;
    assign w_start_info.sub     = w_dec.sub;
    assign w_start_info.reason  = w_dec.reason;
    assign w_start_info.ext     = (r_req.request_id > STD_ID_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_batt      <= '0;
            r_vin_head  <= '0;
            r_vin_mid   <= '0;
            r_vin_tail  <= '0;
            r_codes_a   <= '0;
            r_code_e    <= '0;
            r_dtc_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLED:   r_enabled   <= i_cfg_data[0];
                CFG_BATTERY:   r_batt      <= i_cfg_data[15:0];
                CFG_VIN_HEAD:  r_vin_head  <= i_cfg_data;
                CFG_VIN_MID:   r_vin_mid   <= i_cfg_data;
                CFG_VIN_TAIL:  r_vin_tail  <= i_cfg_data[7:0];
                CFG_DTC_A:     r_codes_a   <= i_cfg_data;
                CFG_DTC_E:     r_code_e    <= i_cfg_data[15:0];
                CFG_DTC_COUNT: r_dtc_count <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session   <= SESSION_DEFAULT;
            r_unlocked  <= 1'b0;
            r_seed      <= '0;
            r_cleared   <= 1'b0;
            r_req_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_req_valid <= 1'b1;
            end else if (r_req_valid) begin
                r_req_valid <= 1'b0;
            end
            // state changes only when the ecu answers
            if (r_req_valid && r_enabled) begin
                if (w_dec.session_we) begin
                    r_session <= w_dec.session_val;
                end
                if (w_dec.lock) begin
                    r_unlocked <= 1'b0;
                end else if (w_dec.unlock) begin
                    r_unlocked <= 1'b1;
                end
                if (w_dec.seed_we) begin
                    r_seed <= r_req.now_ms;
                end
                if (w_dec.clear_codes) begin
                    r_cleared <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
    end

    uds_decode u_decode (
        .i_req  (r_req),
        .i_seed (r_seed),
        .o_dec  (w_dec)
    );

    uds_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_start_info (w_start_info),
        .i_seed       (r_seed),
        .i_batt       (r_batt),
        .i_vin_head   (r_vin_head),
        .i_vin_mid    (r_vin_mid),
        .i_vin_tail   (r_vin_tail),
        .i_codes_a    (r_codes_a),
        .i_code_e     (r_code_e),
        .i_count      (w_count),
        .i_lim        (w_lim),
        .o_busy       (w_busy),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule
